[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication under async reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication under async reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

[hw/rtl/ptsac_pkg.sv]
// ----------------------------------------------------------------------------
// ptsac_pkg
// Types and codes of the per-thread stack address cache.
// ----------------------------------------------------------------------------
package ptsac_pkg;

	localparam logic [2:0] CMD_STORE_BEGIN = 3'd0;
	localparam logic [2:0] CMD_STORE_ADDR  = 3'd1;
	localparam logic [2:0] CMD_LOOKUP      = 3'd2;
	localparam logic [2:0] CMD_MARK_SEEN   = 3'd3;
	localparam logic [2:0] CMD_SWEEP       = 3'd4;

	localparam logic [1:0] ST_MISS  = 2'd0;
	localparam logic [1:0] ST_HIT   = 2'd1;
	localparam logic [1:0] ST_SWEPT = 2'd2;

	typedef struct packed {
		logic [2:0]  command;
		logic [63:0] thread_key;
		logic [63:0] frame_address;
		logic [63:0] base_frame;
		logic [63:0] last_visited;
		logic [5:0]  room;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [4:0]  start_index;
		logic [63:0] cached_address;
		logic        address_valid;
		logic [4:0]  cleared_count;
		logic        run_end;
	} rsp_t;

endpackage

[hw/rtl/ptsac_ram.sv]
// ----------------------------------------------------------------------------
// ptsac_ram
// Generic single-port write, single-port read RAM with registered read.
// ----------------------------------------------------------------------------
module ptsac_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[hw/rtl/ptsac_front.sv]
// ----------------------------------------------------------------------------
// ptsac_front
// Request queue between the input side and the execution engine.
// ----------------------------------------------------------------------------
module ptsac_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  ptsac_pkg::req_t   req_in,
	output logic              full,
	output logic              req_valid,
	output ptsac_pkg::req_t   req_out,
	input  logic              req_take
);

	ptsac_pkg::req_t ent_q [2];
	logic            wp_q, rp_q;
	logic [1:0]      cnt_q;
	logic            wr, rd;

	assign full      = cnt_q == 2'd2;
	assign req_valid = cnt_q != 2'd0;
	assign req_out   = ent_q[rp_q];
	assign wr        = push && !full;
	assign rd        = req_take && req_valid;

	always_ff @(posedge clk) begin
		if (wr) begin
			ent_q[wp_q] <= req_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr) wp_q <= ~wp_q;
			if (rd) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
		end
	end

endmodule

[hw/rtl/ptsac_back.sv]
// ----------------------------------------------------------------------------
// ptsac_back
// Execution engine: slot table, address memory scan and result register.
// ----------------------------------------------------------------------------
module ptsac_back #(
	parameter int SLOT_COUNT      = 16,
	parameter int FRAMES_PER_SLOT = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	input  ptsac_pkg::req_t req,
	output logic            req_take,
	output logic            empty,
	output ptsac_pkg::rsp_t rsp,
	input  logic            pop
);

	localparam int SW  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int FW  = (FRAMES_PER_SLOT > 1) ? $clog2(FRAMES_PER_SLOT) : 1;
	localparam int CW  = $clog2(FRAMES_PER_SLOT + 1);
	localparam int TW  = $clog2(SLOT_COUNT + 1);
	localparam int AW  = $clog2(SLOT_COUNT * FRAMES_PER_SLOT);
	localparam int AWX = (AW > 0) ? AW : 1;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SRCH  = 3'd1;
	localparam logic [2:0] S_CMP   = 3'd2;
	localparam logic [2:0] S_RPLY  = 3'd3;
	localparam logic [2:0] S_EMIT  = 3'd4;
	localparam logic [2:0] S_RWAIT = 3'd5;

	logic [2:0]          state_q;
	logic [63:0]         thr_q  [SLOT_COUNT];
	logic [CW-1:0]       fill_q [SLOT_COUNT];
	logic [SLOT_COUNT-1:0] mark_q;
	logic [TW-1:0]       tally_q;
	logic                open_q;
	logic [SW-1:0]       oslot_q;

	ptsac_pkg::req_t     cur_q;
	logic [SW-1:0]       slot_q;
	logic [CW-1:0]       idx_q;
	logic [CW-1:0]       lfill_q;
	logic [CW-1:0]       start_q;
	logic [CW-1:0]       end_q;
	ptsac_pkg::rsp_t     out_q;
	logic                out_v_q;

	// result register
	assign empty    = !out_v_q;
	assign rsp      = out_q;
	logic  out_free;
	assign out_free = !out_v_q || pop;
	assign req_take = (state_q == S_IDLE) && req_valid && out_free;

	// slot match
	logic [SW-1:0] hit_i, free_i;
	logic          hit_f, free_f;
	always_comb begin
		hit_i = '0; hit_f = 1'b0; free_i = '0; free_f = 1'b0;
		for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
			if (req.thread_key != 64'd0 && thr_q[i] == req.thread_key) begin
				hit_i = SW'(i); hit_f = 1'b1;
			end
			if (thr_q[i] == 64'd0) begin
				free_i = SW'(i); free_f = 1'b1;
			end
		end
	end

	// lookup that needs a scan
	logic lk_go;
	assign lk_go = req.command == ptsac_pkg::CMD_LOOKUP && hit_f
	               && req.frame_address != 64'd0 && fill_q[hit_i] != '0;

	// a new result enters the result register
	logic out_set;
	always_comb begin
		case (state_q)
			S_IDLE:         out_set = req_take && !lk_go;
			S_RPLY, S_EMIT: out_set = out_free;
			default:        out_set = 1'b0;
		endcase
	end

	// sweep count
	logic [SLOT_COUNT-1:0] clr;
	logic [TW-1:0]         ncl;
	always_comb begin
		ncl = '0;
		for (int i = 0; i < SLOT_COUNT; i++) begin
			clr[i] = thr_q[i] != 64'd0 && !mark_q[i];
			ncl    = ncl + TW'(clr[i]);
		end
	end

	// address memory
	logic            we;
	logic [AWX-1:0]  waddr, raddr;
	logic [63:0]     rdata;
	always_comb begin
		waddr = AWX'(oslot_q) * AWX'(FRAMES_PER_SLOT) + AWX'(fill_q[oslot_q]);
		raddr = AWX'(slot_q) * AWX'(FRAMES_PER_SLOT) + AWX'(idx_q);
	end
	assign we = req_take && req.command == ptsac_pkg::CMD_STORE_ADDR && open_q
	            && fill_q[oslot_q] < CW'(FRAMES_PER_SLOT);

	ptsac_ram #(.WIDTH(64), .DEPTH(SLOT_COUNT * FRAMES_PER_SLOT)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(req.frame_address),
		.raddr(raddr), .rdata(rdata)
	);

	logic [CW-1:0] room_c;
	assign room_c = (cur_q.room > 6'(FRAMES_PER_SLOT)) ? CW'(FRAMES_PER_SLOT)
	                : CW'(cur_q.room);

	function automatic ptsac_pkg::rsp_t one(input logic [1:0] st);
		ptsac_pkg::rsp_t r;
		r = '0;
		r.status  = st;
		r.run_end = 1'b1;
		return r;
	endfunction

	function automatic ptsac_pkg::rsp_t res(input logic [1:0] st, input logic [4:0] si,
			input logic [63:0] ad, input logic av, input logic [4:0] cc, input logic re);
		ptsac_pkg::rsp_t r;
		r.status         = st;
		r.start_index    = si;
		r.cached_address = ad;
		r.address_valid  = av;
		r.cleared_count  = cc;
		r.run_end        = re;
		return r;
	endfunction

	always_ff @(posedge clk) begin
		if (req_take) cur_q <= req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			for (int i = 0; i < SLOT_COUNT; i++) begin
				thr_q[i]  <= 64'd0;
				fill_q[i] <= '0;
			end
			mark_q  <= '0;
			tally_q <= '0;
			open_q  <= 1'b0;
			oslot_q <= '0;
			out_v_q <= 1'b0;
			out_q   <= '0;
			slot_q  <= '0;
			idx_q   <= '0;
			lfill_q <= '0;
			start_q <= '0;
			end_q   <= '0;
		end else begin
			out_v_q <= out_set || (out_v_q && !pop);
			case (state_q)
				S_IDLE: begin
					if (req_take) begin
						case (req.command)
							ptsac_pkg::CMD_STORE_BEGIN: begin
								if (req.thread_key == 64'd0 || (req.base_frame != 64'd0
								    && req.last_visited != req.base_frame)
								    || !(hit_f || free_f)) begin
									open_q <= 1'b0;
									out_q  <= one(ptsac_pkg::ST_MISS);
								end else begin
									thr_q[hit_f ? hit_i : free_i]  <= req.thread_key;
									fill_q[hit_f ? hit_i : free_i] <= '0;
									open_q  <= 1'b1;
									oslot_q <= hit_f ? hit_i : free_i;
									out_q   <= one(ptsac_pkg::ST_HIT);
								end
							end
							ptsac_pkg::CMD_STORE_ADDR: begin
								if (we) begin
									fill_q[oslot_q] <= fill_q[oslot_q] + CW'(1);
									out_q <= one(ptsac_pkg::ST_HIT);
								end else begin
									out_q <= one(ptsac_pkg::ST_MISS);
								end
							end
							ptsac_pkg::CMD_LOOKUP: begin
								if (lk_go) begin
									slot_q  <= hit_i;
									lfill_q <= fill_q[hit_i];
									idx_q   <= '0;
									state_q <= S_SRCH;
								end else begin
									out_q <= one(ptsac_pkg::ST_MISS);
								end
							end
							ptsac_pkg::CMD_MARK_SEEN: begin
								if (tally_q < TW'(SLOT_COUNT)) begin
									tally_q <= tally_q + TW'(1);
									if (hit_f) begin
										mark_q[hit_i] <= 1'b1;
										out_q <= one(ptsac_pkg::ST_HIT);
									end else begin
										out_q <= one(ptsac_pkg::ST_MISS);
									end
								end else begin
									out_q <= one(ptsac_pkg::ST_MISS);
								end
							end
							ptsac_pkg::CMD_SWEEP: begin
								for (int i = 0; i < SLOT_COUNT; i++) begin
									if (clr[i]) begin
										thr_q[i]  <= 64'd0;
										fill_q[i] <= '0;
									end
								end
								if (clr[oslot_q]) open_q <= 1'b0;
								mark_q  <= '0;
								tally_q <= '0;
								out_q   <= res(ptsac_pkg::ST_SWEPT, 5'd0, 64'd0, 1'b0,
								               5'(ncl), 1'b1);
							end
							default: out_q <= one(ptsac_pkg::ST_MISS);
						endcase
					end
				end
				S_SRCH: begin
					state_q <= S_CMP;
				end
				S_CMP: begin
					if (rdata == cur_q.frame_address) begin
						start_q <= idx_q;
						end_q   <= ((lfill_q - idx_q) > room_c) ? idx_q + room_c : lfill_q;
						if (room_c == '0) begin
							state_q <= S_EMIT;
							out_q   <= res(ptsac_pkg::ST_HIT, 5'(idx_q), 64'd0, 1'b0,
							               5'd0, 1'b1);
						end else begin
							state_q <= S_RPLY;
						end
					end else if (idx_q + CW'(1) >= lfill_q) begin
						state_q <= S_EMIT;
						out_q   <= one(ptsac_pkg::ST_MISS);
					end else begin
						idx_q   <= idx_q + CW'(1);
						state_q <= S_SRCH;
					end
				end
				S_RPLY: begin
					// rdata holds entry idx_q
					if (out_free) begin
						out_q <= res(ptsac_pkg::ST_HIT, 5'(start_q), rdata, 1'b1, 5'd0,
						             idx_q + CW'(1) == end_q);
						if (idx_q + CW'(1) == end_q) begin
							state_q <= S_IDLE;
						end else begin
							idx_q   <= idx_q + CW'(1);
							state_q <= S_RWAIT;
						end
					end
				end
				S_RWAIT: begin
					state_q <= S_RPLY;
				end
				S_EMIT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

[hw/rtl/per_thread_stack_address_cache_core.sv]
// ----------------------------------------------------------------------------
// per_thread_stack_address_cache_core
// Requests other than lookup are answered straight from the slot table; lookup scans
// the stored addresses one by one through the address RAM read port, then replays
// the matching run, one result per RAM read; one request at a time.
// Reset: asynchronous, slot table, marks, request queue and result register clear; RAM is not cleared.
// ----------------------------------------------------------------------------
module per_thread_stack_address_cache_core #(
	parameter int SLOT_COUNT      = 16,
	parameter int FRAMES_PER_SLOT = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            full,
	input  ptsac_pkg::req_t req,
	output logic            empty,
	input  logic            pop,
	output ptsac_pkg::rsp_t rsp
);

	logic            q_valid, q_take;
	ptsac_pkg::req_t q_req;

	ptsac_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .req_in(req), .full(full),
		.req_valid(q_valid), .req_out(q_req), .req_take(q_take)
	);

	ptsac_back #(.SLOT_COUNT(SLOT_COUNT), .FRAMES_PER_SLOT(FRAMES_PER_SLOT)) u_back (
		.clk(clk), .arst_n(arst_n), .req_valid(q_valid), .req(q_req),
		.req_take(q_take), .empty(empty), .rsp(rsp), .pop(pop)
	);

endmodule

[hw/rtl/ptsac_checker.sv]
// ----------------------------------------------------------------------------
// ptsac_checker
// Port-level checks of the stack address cache.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module ptsac_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            full,
	input logic            empty,
	input logic            pop,
	input ptsac_pkg::rsp_t rsp
);

	`ASSERT_NEXT(a_hold, clk, arst_n, !empty && !pop, !empty && $stable(rsp), "result dropped")
	`ASSERT_IMPL(a_valid, clk, arst_n, !empty && rsp.address_valid, rsp.status == ptsac_pkg::ST_HIT, "address without hit")
	`ASSERT_IMPL(a_sweep, clk, arst_n, !empty && rsp.cleared_count != 5'd0, rsp.status == ptsac_pkg::ST_SWEPT && rsp.run_end, "bad sweep result")
	`ASSERT_IMPL(a_nonaddr, clk, arst_n, !empty && !rsp.address_valid, rsp.run_end && rsp.cached_address == 64'd0, "stray address")

endmodule

bind per_thread_stack_address_cache_core ptsac_checker u_chk (
	.clk(clk), .arst_n(arst_n), .full(full), .empty(empty), .pop(pop), .rsp(rsp)
);

[test/ptsac_response_checker.sv]
// ----------------------------------------------------------------------------
// ptsac_response_checker
// Watches the request and response queues of the stack address cache, keeps
// its own copy of the slot table and predicts every response of each
// accepted request. Responses are compared field by field in order.
// ----------------------------------------------------------------------------
module ptsac_response_checker #(
	parameter int SLOT_COUNT      = 16,
	parameter int FRAMES_PER_SLOT = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  logic            full,
	input  ptsac_pkg::req_t req,
	input  logic            empty,
	input  logic            pop,
	input  ptsac_pkg::rsp_t rsp,
	output int              failures,
	output int              pending
);
	import ptsac_pkg::*;

	logic [63:0] slot_key [SLOT_COUNT];
	int          slot_len [SLOT_COUNT];
	logic [63:0] slot_frames [SLOT_COUNT][FRAMES_PER_SLOT];
	logic        marked [SLOT_COUNT];
	int          mark_tally;
	logic        store_live;
	int          live_slot;
	rsp_t        expected_rsp [$];

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
		failures++;
	endtask

	function automatic int slot_of(input logic [63:0] key);
		if (key == '0)
			return -1;
		for (int i = 0; i < SLOT_COUNT; i++)
			if (slot_key[i] == key)
				return i;
		return -1;
	endfunction

	function automatic void predict_responses(input req_t r);
		rsp_t e;
		int   s;
		int   start;
		int   count;
		int   rm;
		int   cleared;
		e = '0;
		e.run_end = 1'b1;
		case (r.command)
			CMD_STORE_BEGIN: begin
				s = -1;
				if (r.thread_key != '0 && (r.base_frame == '0 || r.last_visited == r.base_frame)) begin
					s = slot_of(r.thread_key);
					if (s < 0)
						for (int i = SLOT_COUNT - 1; i >= 0; i--)
							if (slot_key[i] == '0)
								s = i;
				end
				if (s < 0) begin
					store_live = 1'b0;
				end else begin
					slot_key[s] = r.thread_key;
					slot_len[s] = 0;
					store_live = 1'b1;
					live_slot = s;
					e.status = ST_HIT;
				end
				expected_rsp.push_back(e);
			end
			CMD_STORE_ADDR: begin
				if (store_live && slot_len[live_slot] < FRAMES_PER_SLOT) begin
					slot_frames[live_slot][slot_len[live_slot]] = r.frame_address;
					slot_len[live_slot]++;
					e.status = ST_HIT;
				end
				expected_rsp.push_back(e);
			end
			CMD_LOOKUP: begin
				s = (r.frame_address == '0) ? -1 : slot_of(r.thread_key);
				start = 0;
				if (s >= 0)
					while (start < slot_len[s] && slot_frames[s][start] != r.frame_address)
						start++;
				if (s < 0 || start >= slot_len[s]) begin
					expected_rsp.push_back(e);
				end else begin
					rm = (r.room > FRAMES_PER_SLOT) ? FRAMES_PER_SLOT : r.room;
					count = slot_len[s] - start;
					if (count > rm)
						count = rm;
					e.status = ST_HIT;
					e.start_index = start[4:0];
					if (count == 0)
						expected_rsp.push_back(e);
					for (int k = 0; k < count; k++) begin
						e.cached_address = slot_frames[s][start + k];
						e.address_valid = 1'b1;
						e.run_end = (k + 1 == count);
						expected_rsp.push_back(e);
					end
				end
			end
			CMD_MARK_SEEN: begin
				if (mark_tally < SLOT_COUNT) begin
					mark_tally++;
					s = slot_of(r.thread_key);
					if (s >= 0) begin
						marked[s] = 1'b1;
						e.status = ST_HIT;
					end
				end
				expected_rsp.push_back(e);
			end
			CMD_SWEEP: begin
				cleared = 0;
				for (int i = 0; i < SLOT_COUNT; i++) begin
					if (slot_key[i] != '0 && !marked[i]) begin
						slot_key[i] = '0;
						slot_len[i] = 0;
						cleared++;
						if (store_live && live_slot == i)
							store_live = 1'b0;
					end
					marked[i] = 1'b0;
				end
				mark_tally = 0;
				e.status = ST_SWEPT;
				e.cleared_count = cleared[4:0];
				expected_rsp.push_back(e);
			end
			default:
				expected_rsp.push_back(e);
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rsp_t w;
		if (!arst_n) begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				slot_key[i] = '0;
				slot_len[i] = 0;
				marked[i] = 1'b0;
			end
			mark_tally = 0;
			store_live = 1'b0;
			live_slot = 0;
			expected_rsp.delete();
			failures = 0;
			pending <= 0;
		end else begin
			if (pop && !empty) begin
				if (expected_rsp.size() == 0) begin
					report("unexpected response status", rsp.status, '0);
				end else begin
					w = expected_rsp.pop_front();
					if (rsp.status !== w.status)
						report("status", rsp.status, w.status);
					if (rsp.start_index !== w.start_index)
						report("start_index", rsp.start_index, w.start_index);
					if (rsp.cached_address !== w.cached_address)
						report("cached_address", rsp.cached_address, w.cached_address);
					if (rsp.address_valid !== w.address_valid)
						report("address_valid", rsp.address_valid, w.address_valid);
					if (rsp.cleared_count !== w.cleared_count)
						report("cleared_count", rsp.cleared_count, w.cleared_count);
					if (rsp.run_end !== w.run_end)
						report("run_end", rsp.run_end, w.run_end);
				end
			end
			if (push && !full)
				predict_responses(req);
			pending <= expected_rsp.size();
		end
	end

endmodule

[test/per_thread_stack_address_cache_core_tb.sv]
// ----------------------------------------------------------------------------
// per_thread_stack_address_cache_core_tb
// Directed and random requests (store sequences, lookups, marks and sweeps)
// with bursty input and a stalling output; a checker predicts the responses.
// ----------------------------------------------------------------------------
module per_thread_stack_address_cache_core_tb;
	import ptsac_pkg::*;

	localparam int  CYCLE_LIMIT = 1000000;
	localparam int  ITEM_TARGET = 410;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	req_t        req;
	logic        empty;
	logic        pop;
	rsp_t        rsp;
	int          failures;
	int          pending;
	int          cycles;
	int          sent;
	int          burst_left;
	logic        long_hold;
	logic [63:0] key_pool [20];
	logic [63:0] frame_pool [24];

	per_thread_stack_address_cache_core uut (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .req(req),
		.empty(empty), .pop(pop), .rsp(rsp)
	);

	ptsac_response_checker chk (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .req(req),
		.empty(empty), .pop(pop), .rsp(rsp), .failures(failures), .pending(pending)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// output side: changing stall pattern, one long hold-off on request
	initial begin
		int mode;
		logic held;
		held = 1'b0;
		pop = 1'b0;
		forever begin
			mode = $urandom_range(0, 2);
			repeat ($urandom_range(20, 80)) begin
				@(posedge clk);
				if (long_hold && !held) begin
					held = 1'b1;
					pop <= 1'b0;
					repeat (600) @(posedge clk);
				end
				case (mode)
					0: pop <= 1'b1;
					1: pop <= 1'($urandom_range(0, 1));
					default: pop <= ($urandom_range(0, 4) == 0);
				endcase
			end
		end
	end

	task automatic send(input req_t r);
		if (burst_left == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = $urandom_range(1, 24);
		end
		push <= 1'b1;
		req <= r;
		@(posedge clk);
		while (full)
			@(posedge clk);
		burst_left--;
		sent++;
	endtask

	function automatic req_t noise_req();
		req_t r;
		r.command = 3'($urandom_range(0, 7));
		r.thread_key = {$urandom, $urandom};
		r.frame_address = {$urandom, $urandom};
		r.base_frame = {$urandom, $urandom};
		r.last_visited = ($urandom_range(0, 1)) ? r.base_frame : {$urandom, $urandom};
		r.room = 6'($urandom_range(0, 63));
		return r;
	endfunction

	function automatic req_t cmd_req(input logic [2:0] c, input logic [63:0] key,
			input logic [63:0] frame, input logic [5:0] rm);
		req_t r;
		r = noise_req();
		r.command = c;
		r.thread_key = key;
		r.frame_address = frame;
		r.room = rm;
		return r;
	endfunction

	task automatic store_run(input logic [63:0] key, input int n);
		req_t r;
		r = cmd_req(CMD_STORE_BEGIN, key, '0, '0);
		case ($urandom_range(0, 9))
			0: r.base_frame = '0;
			1: r.last_visited = ~r.base_frame;
			default: r.last_visited = r.base_frame;
		endcase
		send(r);
		for (int i = 0; i < n; i++)
			send(cmd_req(CMD_STORE_ADDR, '0, frame_pool[$urandom_range(0, 23)], '0));
	endtask

	task automatic random_step();
		int pick;
		logic [63:0] key;
		pick = $urandom_range(0, 99);
		key = key_pool[$urandom_range(0, 19)];
		if (pick < 30)
			store_run(key, ($urandom_range(0, 7) == 0) ? $urandom_range(30, 36)
				: $urandom_range(0, 8));
		else if (pick < 60)
			send(cmd_req(CMD_LOOKUP, key, frame_pool[$urandom_range(0, 23)],
				6'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
				: $urandom_range(0, 6))));
		else if (pick < 80)
			send(cmd_req(CMD_MARK_SEEN, key, '0, '0));
		else if (pick < 86)
			send(cmd_req(CMD_SWEEP, '0, '0, '0));
		else
			send(noise_req());
	endtask

	initial begin
		req_t r;
		clk = 1'b0;
		arst_n = 1'b0;
		push = 1'b0;
		req = '0;
		cycles = 0;
		sent = 0;
		burst_left = 0;
		long_hold = 1'b0;
		for (int i = 0; i < 20; i++)
			key_pool[i] = {$urandom, $urandom} | 64'd1;
		for (int i = 0; i < 24; i++)
			frame_pool[i] = {$urandom, $urandom} | 64'd1;
		key_pool[0] = '1;
		frame_pool[0] = '1;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed
		send(cmd_req(CMD_STORE_ADDR, '0, frame_pool[1], '0));
		send(cmd_req(CMD_STORE_BEGIN, '0, '0, '0));
		r = cmd_req(CMD_STORE_BEGIN, key_pool[0], '0, '0);
		r.base_frame = '1;
		r.last_visited = 64'h1;
		send(r);
		r.last_visited = '1;
		send(r);
		send(cmd_req(CMD_STORE_ADDR, '0, frame_pool[0], '0));
		send(cmd_req(CMD_STORE_ADDR, '0, frame_pool[1], '0));
		send(cmd_req(CMD_STORE_ADDR, '0, frame_pool[2], '0));
		send(cmd_req(CMD_LOOKUP, key_pool[0], frame_pool[0], 6'd63));
		send(cmd_req(CMD_LOOKUP, key_pool[0], frame_pool[1], 6'd0));
		send(cmd_req(CMD_LOOKUP, key_pool[0], frame_pool[0], 6'd1));
		send(cmd_req(CMD_LOOKUP, key_pool[0], '0, 6'd5));
		send(cmd_req(CMD_LOOKUP, key_pool[1], frame_pool[0], 6'd5));
		send(cmd_req(CMD_LOOKUP, key_pool[0], frame_pool[5], 6'd5));
		send(cmd_req(CMD_LOOKUP, '0, frame_pool[0], 6'd5));
		send(cmd_req(CMD_MARK_SEEN, '0, '0, '0));
		send(cmd_req(CMD_MARK_SEEN, key_pool[2], '0, '0));
		send(cmd_req(CMD_MARK_SEEN, key_pool[0], '0, '0));
		send(cmd_req(CMD_SWEEP, '0, '0, '0));
		send(cmd_req(CMD_SWEEP, '0, '0, '0));
		send(cmd_req(3'd5, '1, '1, '1));
		send(cmd_req(3'd7, '0, '0, '0));
		send(cmd_req(CMD_STORE_ADDR, '0, frame_pool[3], '0));

		// random
		while (sent < ITEM_TARGET) begin
			random_step();
			if (sent > 150 && !long_hold)
				long_hold <= 1'b1;
			if (sent > 300 && sent < 310) begin
				push <= 1'b0;
				burst_left = 0;
				@(posedge clk);
				while (pending != 0)
					@(posedge clk);
			end
		end
		push <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (failures == 0 && pending == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
